// ===== src/rars_pkg.sv =====
package rars_pkg;

    localparam int unsigned MaxPositions = 1024;
    localparam int unsigned NodeCount    = 4096;
    localparam int unsigned PosW         = 11;
    localparam int unsigned NodeW        = 12;
    localparam int unsigned DataW        = 64;
    localparam int unsigned DepthMax     = 16;
    localparam int unsigned StackW       = 5;
    localparam int unsigned StackDepth   = 32;

    localparam logic CMD_ASSIGN = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_READ,
        ST_VISIT,
        ST_PUSH_R,
        ST_CHILD_L,
        ST_CHILD_R,
        ST_COMBINE,
        ST_OUT
    } rars_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_START,
        OP_POP,
        OP_READ,
        OP_VISIT,
        OP_PUSH_R,
        OP_CHILD_L,
        OP_CHILD_R,
        OP_COMBINE
    } rars_op_t;

    typedef struct packed {
        rars_op_t op;
    } rars_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic stack_empty;
        logic is_query;
    } rars_status_t;

    typedef struct packed {
        logic             post;
        logic [NodeW-1:0] node;
        logic [PosW-1:0]  lo;
        logic [PosW-1:0]  hi;
    } rars_frame_t;

endpackage

// ===== src/rars_ctrl.sv =====
module rars_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic                  cfg_write,
    input  logic                  out_free,
    input  rars_pkg::rars_status_t status,
    output rars_pkg::rars_cmd_t   cmd,
    output logic                  idle,
    output logic                  out_load
);

    rars_pkg::rars_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rars_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rars_pkg::ST_CLEAR: begin
                if (status.clear_done && !cfg_write) state_next = rars_pkg::ST_IDLE;
            end
            rars_pkg::ST_IDLE: begin
                if (cfg_write) state_next = rars_pkg::ST_CLEAR;
                else if (start) state_next = rars_pkg::ST_POP;
            end
            rars_pkg::ST_POP: begin
                if (status.stack_empty) state_next = rars_pkg::ST_OUT;
                else state_next = rars_pkg::ST_READ;
            end
            rars_pkg::ST_READ:    state_next = rars_pkg::ST_VISIT;
            rars_pkg::ST_VISIT:   state_next = rars_pkg::ST_PUSH_R;
            rars_pkg::ST_PUSH_R:  state_next = rars_pkg::ST_CHILD_L;
            rars_pkg::ST_CHILD_L: state_next = rars_pkg::ST_CHILD_R;
            rars_pkg::ST_CHILD_R: state_next = rars_pkg::ST_COMBINE;
            rars_pkg::ST_COMBINE: state_next = rars_pkg::ST_POP;
            rars_pkg::ST_OUT: begin
                if (!status.is_query || out_free) state_next = rars_pkg::ST_IDLE;
            end
            default: state_next = rars_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd.op   = rars_pkg::OP_NONE;
        idle     = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            rars_pkg::ST_CLEAR:   cmd.op = rars_pkg::OP_CLEAR;
            rars_pkg::ST_IDLE: begin
                idle = 1'b1;
                if (start && !cfg_write) cmd.op = rars_pkg::OP_START;
            end
            rars_pkg::ST_POP:     cmd.op = rars_pkg::OP_POP;
            rars_pkg::ST_READ:    cmd.op = rars_pkg::OP_READ;
            rars_pkg::ST_VISIT:   cmd.op = rars_pkg::OP_VISIT;
            rars_pkg::ST_PUSH_R:  cmd.op = rars_pkg::OP_PUSH_R;
            rars_pkg::ST_CHILD_L: cmd.op = rars_pkg::OP_CHILD_L;
            rars_pkg::ST_CHILD_R: cmd.op = rars_pkg::OP_CHILD_R;
            rars_pkg::ST_COMBINE: cmd.op = rars_pkg::OP_COMBINE;
            rars_pkg::ST_OUT:     out_load = status.is_query && out_free;
            default:              cmd.op = rars_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== src/rars_datapath.sv =====
module rars_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rars_pkg::rars_cmd_t          cmd,
    input  logic                         cfg_write,
    input  logic [rars_pkg::PosW-1:0]    cfg_size,
    input  logic                         in_cmd,
    input  logic [rars_pkg::PosW-1:0]    in_start,
    input  logic [rars_pkg::PosW-1:0]    in_end,
    input  logic [rars_pkg::DataW-1:0]   in_value,
    output rars_pkg::rars_status_t       status,
    output logic [rars_pkg::DataW-1:0]   result
);

    localparam int unsigned NW = rars_pkg::NodeW;
    localparam int unsigned PW = rars_pkg::PosW;
    localparam int unsigned DW = rars_pkg::DataW;
    localparam int unsigned SW = rars_pkg::StackW;

    logic [DW-1:0] sum_mem [rars_pkg::NodeCount];
    logic [DW-1:0] pval_mem [rars_pkg::NodeCount];
    logic          pflag_mem [rars_pkg::NodeCount];

    rars_pkg::rars_frame_t stack_mem [rars_pkg::StackDepth];

    logic [PW-1:0] size_reg;
    logic [NW:0]   clr_reg;
    logic          qcmd_reg;
    logic [PW-1:0] i_reg, j_reg;
    logic [DW-1:0] v_reg, acc_reg;
    logic [SW:0]   sp_reg;

    rars_pkg::rars_frame_t fr_reg;
    logic [DW-1:0] rsum_reg, rpval_reg;
    logic          rflag_reg;
    logic [DW-1:0] nsum_reg;
    logic          recurse_reg;

    logic [PW-1:0]  mid;
    logic [NW-1:0]  lnode, rnode;
    logic           l_in, r_in;
    logic [PW-1:0]  cnt;
    logic [DW-1:0]  cur_val;
    logic           cur_pend;
    logic           disjoint, covered;
    logic [SW-1:0]  sp_idx;

    assign mid     = PW'((12'(fr_reg.lo) + 12'(fr_reg.hi)) >> 1);
    assign lnode   = NW'({fr_reg.node, 1'b0});
    assign rnode   = NW'({fr_reg.node, 1'b1});
    assign l_in    = ~fr_reg.node[NW-1];
    assign r_in    = ~fr_reg.node[NW-1];
    assign cnt     = fr_reg.hi - fr_reg.lo + PW'(1);
    assign sp_idx  = sp_reg[SW-1:0] - SW'(1);
    assign cur_pend = rflag_reg;
    assign cur_val  = rpval_reg;
    assign disjoint = (fr_reg.hi < i_reg) || (j_reg < fr_reg.lo);
    assign covered  = (fr_reg.lo >= i_reg) && (fr_reg.hi <= j_reg);

    assign status.clear_done  = clr_reg[NW];
    assign status.stack_empty = (sp_reg == '0);
    assign status.is_query    = qcmd_reg;
    assign result             = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= PW'(rars_pkg::MaxPositions);
            clr_reg  <= '0;
            sp_reg   <= '0;
        end else begin
            if (cfg_write) begin
                if (cfg_size == '0) size_reg <= PW'(1);
                else if (cfg_size > PW'(rars_pkg::MaxPositions))
                    size_reg <= PW'(rars_pkg::MaxPositions);
                else size_reg <= cfg_size;
                clr_reg <= '0;
            end else if (cmd.op == rars_pkg::OP_CLEAR && !clr_reg[NW]) begin
                clr_reg <= clr_reg + (NW+1)'(1);
            end
            case (cmd.op)
                rars_pkg::OP_START: begin
                    sp_reg <= (in_start <= in_end) ? (SW+1)'(1) : '0;
                end
                rars_pkg::OP_POP: begin
                    if (sp_reg != '0) sp_reg <= sp_reg - (SW+1)'(1);
                end
                rars_pkg::OP_PUSH_R: begin
                    if (!fr_reg.post) sp_reg <= sp_reg + (recurse_reg ? (SW+1)'(3) : '0);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            rars_pkg::OP_CLEAR: begin
                if (!clr_reg[NW]) begin
                    sum_mem[clr_reg[NW-1:0]]   <= '0;
                    pval_mem[clr_reg[NW-1:0]]  <= '0;
                    pflag_mem[clr_reg[NW-1:0]] <= 1'b0;
                end
            end
            rars_pkg::OP_START: begin
                qcmd_reg <= in_cmd;
                i_reg    <= in_start;
                j_reg    <= in_end;
                v_reg    <= in_value;
                acc_reg  <= '0;
                stack_mem[0] <= '{post: 1'b0, node: NW'(1), lo: PW'(1), hi: size_reg};
            end
            rars_pkg::OP_POP: begin
                if (sp_reg != '0) fr_reg <= stack_mem[sp_idx];
            end
            rars_pkg::OP_READ: begin
                rsum_reg  <= sum_mem[fr_reg.post ? lnode : fr_reg.node];
                rpval_reg <= pval_mem[fr_reg.node];
                rflag_reg <= pflag_mem[fr_reg.node];
                nsum_reg  <= sum_mem[rnode];
            end
            rars_pkg::OP_VISIT: begin
                recurse_reg <= !fr_reg.post && !disjoint && !covered;
                if (fr_reg.post) begin
                    sum_mem[fr_reg.node] <= (l_in ? rsum_reg : '0) + (r_in ? nsum_reg : '0);
                end else if (cur_pend) begin
                    sum_mem[fr_reg.node]   <= DW'(cnt) * cur_val;
                    pflag_mem[fr_reg.node] <= 1'b0;
                    rsum_reg <= DW'(cnt) * cur_val;
                end
            end
            rars_pkg::OP_PUSH_R: begin
                if (!fr_reg.post) begin
                    if (cur_pend && fr_reg.hi != fr_reg.lo) begin
                        if (l_in) begin
                            pval_mem[lnode] <= cur_val;
                            pflag_mem[lnode] <= 1'b1;
                        end
                    end else if (!disjoint && covered && qcmd_reg == rars_pkg::CMD_ASSIGN) begin
                        sum_mem[fr_reg.node]   <= DW'(cnt) * v_reg;
                        pflag_mem[fr_reg.node] <= 1'b0;
                    end
                    if (!disjoint && covered && qcmd_reg == rars_pkg::CMD_QUERY)
                        acc_reg <= acc_reg + rsum_reg;
                    if (recurse_reg) begin
                        stack_mem[sp_reg[SW-1:0]] <=
                            '{post: 1'b1, node: fr_reg.node, lo: fr_reg.lo, hi: fr_reg.hi};
                        stack_mem[SW'(sp_reg[SW-1:0] + SW'(1))] <=
                            '{post: 1'b0, node: rnode, lo: mid + PW'(1), hi: fr_reg.hi};
                        stack_mem[SW'(sp_reg[SW-1:0] + SW'(2))] <=
                            '{post: 1'b0, node: lnode, lo: fr_reg.lo, hi: mid};
                    end
                end
            end
            rars_pkg::OP_CHILD_L: begin
                if (!fr_reg.post) begin
                    if (cur_pend && fr_reg.hi != fr_reg.lo && r_in) begin
                        pval_mem[rnode]  <= cur_val;
                        pflag_mem[rnode] <= 1'b1;
                    end
                end
            end
            rars_pkg::OP_CHILD_R: begin
                if (!fr_reg.post && cur_pend && !disjoint && covered
                        && qcmd_reg == rars_pkg::CMD_ASSIGN) begin
                    sum_mem[fr_reg.node] <= DW'(cnt) * v_reg;
                    pflag_mem[fr_reg.node] <= 1'b0;
                end
            end
            rars_pkg::OP_COMBINE: begin
                if (!fr_reg.post && !disjoint && covered && fr_reg.hi != fr_reg.lo
                        && qcmd_reg == rars_pkg::CMD_ASSIGN) begin
                    if (l_in) begin
                        pval_mem[lnode] <= v_reg;
                        pflag_mem[lnode] <= 1'b1;
                    end
                    if (r_in) begin
                        pval_mem[rnode] <= v_reg;
                        pflag_mem[rnode] <= 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== src/range_assign_range_sum_tree_core.sv =====
// Lazy segment tree over positions 1..active_size with range assign
// (cmd 0) and range sum (cmd 1); sums wrap modulo 2^64. Nodes are
// visited one at a time from an explicit stack; each stack frame goes
// through the pop, read, visit, push, left-child, right-child and
// combine states in turn, and the node memories are read at no more
// than two addresses a cycle. A query whose previous result is still
// unread waits in its output state until that result is taken. After
// reset and after every active_size write a clearing pass over all 4096
// node entries runs before the first item is taken; a size write is
// taken only between items. Only queries produce a result item.
module range_assign_range_sum_tree_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_cmd,
    input  logic [rars_pkg::PosW-1:0]           s_range_start,
    input  logic [rars_pkg::PosW-1:0]           s_range_end,
    input  logic signed [rars_pkg::DataW-1:0]   s_assign_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [rars_pkg::DataW-1:0]   m_range_sum,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rars_pkg::PosW-1:0]           cfg_data
);

    rars_pkg::rars_cmd_t    cmd;
    rars_pkg::rars_status_t status;
    logic                   idle, out_load, cfg_write, start, out_free;
    logic [rars_pkg::DataW-1:0] result;
    logic                   m_valid_reg;
    logic [rars_pkg::DataW-1:0] m_data_reg;

    assign cfg_ready = idle;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s_ready   = idle && !cfg_valid;
    assign start     = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_range_sum = m_data_reg;

    rars_ctrl u_ctrl (
        .aclk, .aresetn, .start, .cfg_write, .out_free, .status,
        .cmd, .idle, .out_load
    );

    rars_datapath u_dp (
        .aclk, .aresetn, .cmd, .cfg_write, .cfg_size(cfg_data),
        .in_cmd(s_cmd), .in_start(s_range_start), .in_end(s_range_end),
        .in_value(s_assign_value), .status, .result
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) m_data_reg <= result;
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_range_sum))
        else $error("result changed under stall");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !idle |-> !s_ready)
        else $error("item taken while busy");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result overwritten");

endmodule
